[sv/spq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// Depends on nothing; imported by the queue and its checker.
package spq_pkg;

   localparam int SPQ_QUEUE_DEPTH = 16;

   localparam int KEY_W    = 16;
   localparam int HANDLE_W = 8;
   localparam int OCC_W    = 5;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_PEEK = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_CMP,
      ST_PUSH_PLACE,
      ST_POP_READ,
      ST_FINISH
   } spq_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } spq_entry_type;

   typedef struct packed {
      logic                entry_valid;
      logic [HANDLE_W-1:0] entry_handle;
      logic [KEY_W-1:0]    entry_key;
      logic                queue_empty;
      logic                push_dropped;
   } spq_result_type;

endpackage

[sv/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// Sorted priority queue. A push into an empty or full queue and opcode 3 go straight to the finish
// state, pop and peek first read the served slot if any, and other pushes walk the held entries,
// shifting each smaller one. The walk compares one slot per cycle through the memory's one read port.
// One word is in flight at a time; a new word can be taken in the cycle after the result is loaded.
// Reset (synchronous, active high) empties the queue at once and stalls the request side while
// held; the entry memory is not cleared, since only entries below the fill count are ever read.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPQ_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [HANDLE_W-1:0] req_handle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_entry_valid,
   output logic [HANDLE_W-1:0] rsp_entry_handle,
   output logic [KEY_W-1:0]    rsp_entry_key,
   output logic                rsp_queue_empty,
   output logic                rsp_push_dropped,
   output logic [OCC_W-1:0]    rsp_occupancy
);

   // Address width covers the slots; the count must also hold the full depth itself.
   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   // Entries are kept sorted with the largest key at slot 0; the served entry sits in the
   // last occupied slot, count - 1. The memory has one write and one registered read port.
   spq_entry_type mem [QUEUE_DEPTH];
   spq_entry_type rd_data_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_wr_addr;
   spq_entry_type     mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_rd_addr;

   spq_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;

   // The accepted word is held here while the walk runs.
   logic [1:0]    op_ff, op_in;
   spq_entry_type new_ff, new_in;

   // The result is built in res_ff and moved into the output register when that is free,
   // so a finished word may wait downstream while the next one is being taken.
   spq_result_type res_ff, res_in;
   spq_result_type rsp_ff, rsp_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0] count_dec;
   logic [CNT_W-1:0] pos_dec;
   logic [CNT_W-1:0] pos_dec2;
   spq_entry_type    req_entry;

   assign count_dec = count_ff - CNT_W'(1);
   assign pos_dec   = pos_ff - CNT_W'(1);
   assign pos_dec2  = pos_ff - CNT_W'(2);
   assign req_entry = '{key: req_key, handle: req_handle};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      op_ff  <= op_in;
      new_ff <= new_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      occ_ff <= occ_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      new_in       = new_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wr_addr  = pos_ff[ADDR_W-1:0];
      mem_wdata    = new_ff;
      mem_re       = 1'b0;
      mem_rd_addr  = count_dec[ADDR_W-1:0];
      req_stall    = (state_ff != ST_IDLE) || reset;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_opcode;
               new_in = req_entry;
               res_in = '0;
               case (req_opcode)
                  OP_PUSH: begin
                     if (count_ff == FULL_COUNT) begin
                        res_in.push_dropped = 1'b1;
                        state_in = ST_FINISH;
                     end else if (count_ff == '0) begin
                        // Nothing to walk past: the word goes straight into slot 0.
                        mem_we      = 1'b1;
                        mem_wr_addr = '0;
                        mem_wdata   = req_entry;
                        count_in    = CNT_W'(1);
                        state_in    = ST_FINISH;
                     end else begin
                        mem_re   = 1'b1;
                        pos_in   = count_ff;
                        state_in = ST_PUSH_CMP;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (count_ff == '0) begin
                        res_in.queue_empty = 1'b1;
                        state_in = ST_FINISH;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = ST_POP_READ;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_PUSH_CMP: begin
            // rd_data_ff holds slot pos - 1. A strictly smaller key moves one slot towards the tail;
            // an equal or larger key stops the walk, so the newest of equal keys is served first.
            mem_we = 1'b1;
            if (rd_data_ff.key < new_ff.key) begin
               mem_wdata = rd_data_ff;
               pos_in    = pos_dec;
               if (pos_dec != '0) begin
                  mem_re      = 1'b1;
                  mem_rd_addr = pos_dec2[ADDR_W-1:0];
               end else begin
                  state_in = ST_PUSH_PLACE;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = ST_FINISH;
            end
         end

         ST_PUSH_PLACE: begin
            // Every held entry was smaller, so the new word lands in slot 0.
            mem_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_FINISH;
         end

         ST_POP_READ: begin
            res_in.entry_valid  = 1'b1;
            res_in.entry_key    = rd_data_ff.key;
            res_in.entry_handle = rd_data_ff.handle;
            if (op_ff == OP_POP) begin
               count_in = count_dec;
            end
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               occ_in       = OCC_W'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_valid  = rsp_ff.entry_valid;
   assign rsp_entry_handle = rsp_ff.entry_handle;
   assign rsp_entry_key    = rsp_ff.entry_key;
   assign rsp_queue_empty  = rsp_ff.queue_empty;
   assign rsp_push_dropped = rsp_ff.push_dropped;
   assign rsp_occupancy    = occ_ff;

endmodule

[sv/spq_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue, and the bind that attaches them.
// Depends on spq_pkg.
module spq_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPQ_QUEUE_DEPTH
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic                rsp_entry_valid,
   input logic [HANDLE_W-1:0] rsp_entry_handle,
   input logic [KEY_W-1:0]    rsp_entry_key,
   input logic                rsp_queue_empty,
   input logic                rsp_push_dropped,
   input logic [OCC_W-1:0]    rsp_occupancy
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_key)
         && $stable(rsp_entry_handle) && $stable(rsp_occupancy))
      else $error("stalled result word changed");

   // A refused push can only come from a full queue.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |-> rsp_occupancy == OCC_W'(QUEUE_DEPTH))
      else $error("push dropped while the queue was not full");

   // An empty report leaves nothing held and returns no entry.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_occupancy == '0 && !rsp_entry_valid)
      else $error("empty report with entries held");

   // A new word is taken only after the previous result has been produced.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in flight");

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);
